@@ rtl/assert_macros.svh @@
// shared assertion macros, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant
`define ILPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ILPM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ILPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ilpm_pkg.sv @@
package ilpm_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int USED_W     = $clog2(NODE_COUNT + 1);

  localparam logic [31:0] HOP_NONE = 32'hffff_ffff;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_FWD = 1'b1;

  localparam logic [2:0] VERDICT_LOCAL       = 3'd0;
  localparam logic [2:0] VERDICT_FORWARDED   = 3'd1;
  localparam logic [2:0] VERDICT_TTL_EXPIRED = 3'd2;
  localparam logic [2:0] VERDICT_NO_ROUTE    = 3'd3;
  localparam logic [2:0] VERDICT_ADDED       = 3'd4;
  localparam logic [2:0] VERDICT_FULL        = 3'd5;

  typedef struct packed {
    logic        req_type;
    logic [31:0] prefix;
    logic [5:0]  prefix_len;
    logic [31:0] route_next_hop;
    logic [31:0] hdr_word0;
    logic [31:0] hdr_word1;
    logic [31:0] hdr_word2;
    logic [31:0] hdr_word3;
    logic [31:0] hdr_word4;
  } ilpm_req_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] next_hop;
    logic [31:0] new_word2;
  } ilpm_resp_t;

  // one trie node: route flag, next hop, right and left child (0 = none)
  typedef struct packed {
    logic             valid;
    logic [31:0]      hop;
    logic [IDX_W-1:0] kid1;
    logic [IDX_W-1:0] kid0;
  } ilpm_node_t;

  localparam int NODE_W = $bits(ilpm_node_t);

  // node store access from the walker
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    ilpm_node_t       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ilpm_mem_cmd_t;

  function automatic logic [IDX_W-1:0] kid_of(ilpm_node_t n, logic b);
    return b ? n.kid1 : n.kid0;
  endfunction

  function automatic ilpm_node_t with_kid(ilpm_node_t n, logic b, logic [IDX_W-1:0] k);
    ilpm_node_t r;
    r = n;
    if (b) begin
      r.kid1 = k;
    end else begin
      r.kid0 = k;
    end
    return r;
  endfunction

endpackage

@@ rtl/ilpm_ram.sv @@
module ilpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ rtl/ilpm_ctrl.sv @@
`include "assert_macros.svh"

module ilpm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ilpm_pkg::ilpm_req_t   in_req,
  input  logic [31:0]           local_addr,
  output logic                  res_valid,
  input  logic                  res_ready,
  output ilpm_pkg::ilpm_resp_t  res,
  output ilpm_pkg::ilpm_mem_cmd_t mem_cmd,
  input  ilpm_pkg::ilpm_node_t  mem_rdata
);

  import ilpm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_LINK, S_GROW, S_SETHOP, S_SUM1, S_SUM2, S_FOLD, S_RESP
  } state_t;

  state_t           state_r, state_nxt;
  ilpm_req_t        req_r, req_nxt;
  logic [31:0]      bits_r, bits_nxt;
  logic [5:0]       depth_r, depth_nxt;
  logic [5:0]       lim_r, lim_nxt;
  logic [5:0]       rem_r, rem_nxt;
  logic             at_root_r, at_root_nxt;
  logic [IDX_W-1:0] cur_idx_r, cur_idx_nxt;
  ilpm_node_t       node_r, node_nxt;
  ilpm_node_t       root_r, root_nxt;
  logic [31:0]      best_r, best_nxt;
  logic             found_r, found_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [19:0]      sum_r, sum_nxt;
  ilpm_resp_t       res_r, res_nxt;

  ilpm_node_t       node_cur;
  logic [IDX_W-1:0] kid;
  logic [5:0]       missing;
  logic [USED_W:0]  need;
  logic             found_all;
  logic [7:0]       ttl;
  logic [31:0]      nw2;
  logic [16:0]      fold1;
  logic [15:0]      fold2;
  logic [IDX_W-1:0] new_idx;
  ilpm_node_t       leaf;
  ilpm_node_t       hop_node;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;

  always_comb begin
    node_cur  = at_root_r ? root_r : mem_rdata;
    kid       = kid_of(node_cur, bits_r[31]);
    missing   = lim_r - depth_r;
    need      = {{(USED_W + 1 - 6){1'b0}}, missing} + {1'b0, used_r};
    found_all = found_r | node_cur.valid;
    ttl       = req_r.hdr_word2[31:24];
    nw2       = {ttl - 8'd1, req_r.hdr_word2[23:16], 16'h0000};
    fold1     = {1'b0, sum_r[15:0]} + {13'd0, sum_r[19:16]};
    fold2     = fold1[15:0] + {15'd0, fold1[16]};
    new_idx   = used_r[IDX_W-1:0];

    leaf       = '0;
    leaf.valid = (req_r.route_next_hop != HOP_NONE);
    leaf.hop   = leaf.valid ? req_r.route_next_hop : 32'h0;

    hop_node       = node_r;
    hop_node.valid = leaf.valid;
    hop_node.hop   = leaf.hop;

    state_nxt   = state_r;
    req_nxt     = req_r;
    bits_nxt    = bits_r;
    depth_nxt   = depth_r;
    lim_nxt     = lim_r;
    rem_nxt     = rem_r;
    at_root_nxt = at_root_r;
    cur_idx_nxt = cur_idx_r;
    node_nxt    = node_r;
    root_nxt    = root_r;
    best_nxt    = best_r;
    found_nxt   = found_r;
    used_nxt    = used_r;
    sum_nxt     = sum_r;
    res_nxt     = res_r;
    mem_cmd     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt     = in_req;
          depth_nxt   = '0;
          at_root_nxt = 1'b1;
          cur_idx_nxt = '0;
          found_nxt   = 1'b0;
          best_nxt    = '0;
          res_nxt     = '0;
          if (in_req.req_type == REQ_ADD) begin
            bits_nxt  = in_req.prefix;
            lim_nxt   = (in_req.prefix_len > 6'd32) ? 6'd32 : in_req.prefix_len;
            state_nxt = S_WALK;
          end else if (in_req.hdr_word4 == local_addr) begin
            res_nxt.verdict = VERDICT_LOCAL;
            state_nxt       = S_RESP;
          end else begin
            bits_nxt  = in_req.hdr_word4;
            lim_nxt   = 6'd32;
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (node_cur.valid) begin
          found_nxt = 1'b1;
          best_nxt  = node_cur.hop;
        end
        if (depth_r == lim_r || kid == '0) begin
          node_nxt = node_cur;
          if (req_r.req_type == REQ_ADD) begin
            rem_nxt = missing;
            if (need > (USED_W + 1)'(NODE_COUNT)) begin
              res_nxt.verdict = VERDICT_FULL;
              state_nxt       = S_RESP;
            end else if (missing == '0) begin
              state_nxt = S_SETHOP;
            end else begin
              state_nxt = S_LINK;
            end
          end else if (!found_all) begin
            res_nxt.verdict = VERDICT_NO_ROUTE;
            state_nxt       = S_RESP;
          end else if (ttl <= 8'd1) begin
            res_nxt.verdict = VERDICT_TTL_EXPIRED;
            state_nxt       = S_RESP;
          end else begin
            state_nxt = S_SUM1;
          end
        end else begin
          // fetch the child; its registered read data steers the next walk step
          mem_cmd.re  = 1'b1;
          mem_cmd.raddr = kid;
          cur_idx_nxt = kid;
          depth_nxt   = depth_r + 6'd1;
          bits_nxt    = {bits_r[30:0], 1'b0};
          at_root_nxt = 1'b0;
        end
      end

      S_LINK: begin
        // hang the first fresh node under the deepest existing one
        if (cur_idx_r == '0) begin
          root_nxt = with_kid(node_r, bits_r[31], new_idx);
        end else begin
          mem_cmd.we    = 1'b1;
          mem_cmd.waddr = cur_idx_r;
          mem_cmd.wdata = with_kid(node_r, bits_r[31], new_idx);
        end
        bits_nxt  = {bits_r[30:0], 1'b0};
        state_nxt = S_GROW;
      end

      S_GROW: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = new_idx;
        if (rem_r == 6'd1) begin
          mem_cmd.wdata   = leaf;
          res_nxt.verdict = VERDICT_ADDED;
          state_nxt       = S_RESP;
        end else begin
          mem_cmd.wdata = with_kid(ilpm_node_t'('0), bits_r[31], new_idx + IDX_W'(1));
        end
        used_nxt = used_r + USED_W'(1);
        rem_nxt  = rem_r - 6'd1;
        bits_nxt = {bits_r[30:0], 1'b0};
      end

      S_SETHOP: begin
        if (cur_idx_r == '0) begin
          root_nxt = hop_node;
        end else begin
          mem_cmd.we    = 1'b1;
          mem_cmd.waddr = cur_idx_r;
          mem_cmd.wdata = hop_node;
        end
        res_nxt.verdict = VERDICT_ADDED;
        state_nxt       = S_RESP;
      end

      S_SUM1: begin
        sum_nxt = 20'(req_r.hdr_word0[31:16]) + 20'(req_r.hdr_word0[15:0])
                + 20'(req_r.hdr_word1[31:16]) + 20'(req_r.hdr_word1[15:0])
                + 20'(req_r.hdr_word3[31:16]);
        state_nxt = S_SUM2;
      end

      S_SUM2: begin
        sum_nxt = sum_r + 20'(req_r.hdr_word3[15:0]) + 20'(req_r.hdr_word4[31:16])
                + 20'(req_r.hdr_word4[15:0]) + 20'(nw2[31:16]);
        state_nxt = S_FOLD;
      end

      S_FOLD: begin
        res_nxt.verdict   = VERDICT_FORWARDED;
        res_nxt.next_hop  = best_r;
        res_nxt.new_word2 = {nw2[31:16], ~fold2};
        state_nxt         = S_RESP;
      end

      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    bits_r    <= bits_nxt;
    depth_r   <= depth_nxt;
    lim_r     <= lim_nxt;
    rem_r     <= rem_nxt;
    at_root_r <= at_root_nxt;
    cur_idx_r <= cur_idx_nxt;
    node_r    <= node_nxt;
    best_r    <= best_nxt;
    found_r   <= found_nxt;
    sum_r     <= sum_nxt;
    res_r     <= res_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      root_r  <= '0;
      used_r  <= USED_W'(1);
    end else begin
      state_r <= state_nxt;
      root_r  <= root_nxt;
      used_r  <= used_nxt;
    end
  end

  `ILPM_ASSERT(a_used_range, (used_r != '0) && (used_r <= USED_W'(NODE_COUNT)), "node count out of range")
  `ILPM_ASSERT_IMPL(a_root_not_in_ram, mem_cmd.we, mem_cmd.waddr != '0, "root written to node store")
  `ILPM_ASSERT_IMPL(a_grow_has_room, state_r == S_GROW, used_r < USED_W'(NODE_COUNT), "allocation past end of store")

endmodule

@@ rtl/ipv4_lpm_trie_forwarder_unit.sv @@
// channel   direction  handshake                payload
// in_       in         in_valid / in_ready      in_req   (ilpm_req_t)
// out_      out        out_valid / out_ready    out_resp (ilpm_resp_t)
// cfg_      in         cfg_valid / cfg_ready    cfg_data (local address)
//
// one request at a time; a forward walks one trie level per step (root plus up to 32), then
// three checksum states, a result state and an idle state; an add walks the existing path,
// then S_LINK and S_GROW write one new node per missing level, or S_SETHOP sets the hop; a
// full table answers with no write; local delivery skips the trie, S_IDLE straight to S_RESP
// synchronous active-low reset: root empty, one node in use, no clearing pass needed
// a waiting result sits in the output register; the walker stalls only behind a second one
`include "assert_macros.svh"

module ipv4_lpm_trie_forwarder_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ilpm_pkg::ilpm_req_t  in_req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ilpm_pkg::ilpm_resp_t out_resp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data
);

  import ilpm_pkg::*;

  logic [31:0]   local_addr_r;
  logic          out_valid_r;
  ilpm_resp_t    out_resp_r;

  logic          res_valid;
  logic          res_ready;
  ilpm_resp_t    res;
  ilpm_mem_cmd_t mem_cmd;
  ilpm_node_t    mem_rdata;

  // register write is always taken; the user must write it only between requests, not enforced here
  assign cfg_ready = 1'b1;

  // output register frees as it is drained
  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_resp  = out_resp_r;

  // trie walker, allocator and header rewrite
  ilpm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req     (in_req),
    .local_addr (local_addr_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_cmd    (mem_cmd),
    .mem_rdata  (mem_rdata)
  );

  // node store, entry 0 unused (the root lives in a register)
  ilpm_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_nodes (
    .clk   (clk),
    .we    (mem_cmd.we),
    .waddr (mem_cmd.waddr),
    .wdata (mem_cmd.wdata),
    .re    (mem_cmd.re),
    .raddr (mem_cmd.raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_resp_r <= res;
    end
    if (!rst_n) begin
      local_addr_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        local_addr_r <= cfg_data;
      end
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `ILPM_ASSERT_NEXT(a_busy_after_request, in_valid && in_ready, !in_ready, "second request taken while busy")

endmodule
